// ----- rtl/core/sparse_expected_distance_dot_defines.svh -----
// Assertion helpers for the sparse expected distance block.
`ifndef SPARSE_EXPECTED_DISTANCE_DOT_DEFINES_SVH
`define SPARSE_EXPECTED_DISTANCE_DOT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SEDD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define SEDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/core/sedd_pkg.sv -----
`default_nettype none
package sedd_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W       = 16;
	localparam int VAL_W       = 32;
	localparam int RES_W       = 64;
	localparam int DIM_W       = 17;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int RAM_W       = IDX_W + VAL_W;

	localparam logic [MODE_W-1:0] MODE_SQD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DOT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LEN = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RSV = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAC = 2'd2;

	localparam logic signed [RES_W-1:0] SAT_MAX = {1'b0, {(RES_W-1){1'b1}}};
	localparam logic signed [RES_W-1:0] SAT_MIN = {1'b1, {(RES_W-1){1'b0}}};
	localparam logic signed [RES_W-1:0] NEG_ONE = -(64'sd1 <<< (2 * FRAC_BITS));

	typedef struct packed {
		logic                    req_type;
		logic [IDX_W-1:0]        entry_index;
		logic signed [VAL_W-1:0] entry_value;
		logic                    last_entry;
	} req_t;

	typedef struct packed {
		logic signed [RES_W-1:0] result_value;
		logic [CNT_W-1:0]        common_count;
		logic                    below_threshold;
	} rsp_t;

	typedef struct packed {
		req_t req;
		logic is_load;
		logic is_last;
	} item_t;

	typedef struct packed {
		logic [DIM_W-1:0] dimension;
		logic [DIM_W-1:0] fraction;
	} cfg_t;

	typedef struct packed {
		logic signed [RES_W-1:0] acc;
		logic [CNT_W-1:0]        match_cnt;
		logic [MODE_W-1:0]       mode;
	} fin_req_t;

	function automatic logic [MODE_W-1:0] norm_mode(input logic [MODE_W-1:0] m);
		return (m == MODE_RSV) ? MODE_SQD : m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sedd_ram.sv -----
`default_nettype none
module sedd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/sedd_front.sv -----
`default_nettype none
module sedd_front import sedd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      head_valid,
	output item_t     head,
	input  wire logic pop
);
	item_t      slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item;

	assign req_ready  = (count_q != 2'd2);
	assign push       = req_valid && req_ready;
	assign head_valid = (count_q != 2'd0);
	assign head       = slot_q[rd_ptr_q];

	// classify: loads, streamed entries, and streamed entries that close a vector
	always_comb begin
		item.req     = req;
		item.is_load = !req.req_type;
		item.is_last = req.req_type && req.last_entry;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			count_q <= 2'(count_q + {1'b0, push} - {1'b0, pop});
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/sedd_merge.sv -----
`default_nettype none
module sedd_merge import sedd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire item_t             head,
	output logic                   pop,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic              fin_busy,
	output logic                   fin_start,
	output fin_req_t               fin_req
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_END  = 2'd3;
	localparam int PROD_W = 68;

	logic [1:0]              state_q;
	logic [CNT_W-1:0]        count_q, ptr_q, match_q;
	logic signed [RES_W-1:0] acc_q;
	logic                    streamed_q;
	logic signed [PROD_W-1:0] prod_s1;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
	logic [RAM_W-1:0]        ram_rdata;
	logic [CNT_W-1:0]        ptr_inc;
	logic [IDX_W-1:0]        stored_idx;
	logic signed [VAL_W-1:0] stored_val;
	logic                    less, equal, room;
	logic [MODE_W-1:0]       mode_now;
	logic signed [32:0]      diff;
	logic [32:0]             absd;
	logic signed [33:0]      op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [RES_W-1:0] term;
	logic signed [RES_W:0]   sum;
	logic signed [RES_W-1:0] acc_next;

	assign mode_now   = norm_mode(mode);
	assign ptr_inc    = CNT_W'(ptr_q + 1'b1);
	assign stored_idx = ram_rdata[RAM_W-1 -: IDX_W];
	assign stored_val = $signed(ram_rdata[VAL_W-1:0]);
	assign less       = stored_idx < head.req.entry_index;
	assign equal      = stored_idx == head.req.entry_index;
	assign room       = count_q < CNT_W'(MAX_ENTRIES);

	assign ram_we    = (state_q == ST_IDLE) && head_valid && head.is_load && (streamed_q || room);
	assign ram_waddr = streamed_q ? '0 : count_q[ADDR_W-1:0];
	assign ram_raddr = (state_q == ST_CMP) ? ptr_inc[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];

	sedd_ram #(.WIDTH(RAM_W), .DEPTH(MAX_ENTRIES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({head.req.entry_index, head.req.entry_value}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// one shared multiplier: product of values, or square of their difference
	always_comb begin
		diff = $signed({stored_val[VAL_W-1], stored_val})
		     - $signed({head.req.entry_value[VAL_W-1], head.req.entry_value});
		absd = diff[32] ? 33'(-diff) : 33'(diff);
		if (mode_now == MODE_DOT) begin
			op_a = $signed({{2{stored_val[VAL_W-1]}}, stored_val});
			op_b = $signed({{2{head.req.entry_value[VAL_W-1]}}, head.req.entry_value});
		end else begin
			op_a = $signed({1'b0, absd});
			op_b = $signed({1'b0, absd});
		end
		prod = op_a * op_b;
	end

	// clip the square, then saturating add
	always_comb begin
		term = (prod_s1 > $signed({4'b0000, SAT_MAX})) ? SAT_MAX : prod_s1[RES_W-1:0];
		sum  = $signed({acc_q[RES_W-1], acc_q}) + $signed({term[RES_W-1], term});
		if (sum[RES_W] != sum[RES_W-1]) begin
			acc_next = sum[RES_W] ? SAT_MIN : SAT_MAX;
		end else begin
			acc_next = sum[RES_W-1:0];
		end
	end

	always_comb begin
		pop = 1'b0;
		fin_start = 1'b0;
		if (state_q == ST_IDLE && head_valid && head.is_load) pop = 1'b1;
		if (state_q == ST_END) begin
			if (!head.is_last) begin
				pop = 1'b1;
			end else if (!fin_busy) begin
				pop = 1'b1;
				fin_start = 1'b1;
			end
		end
	end

	assign fin_req = '{acc: acc_q, match_cnt: match_q, mode: mode_now};

	always_ff @(posedge clk) begin
		if (state_q == ST_CMP && !less && equal) begin
			prod_s1 <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			ptr_q      <= '0;
			match_q    <= '0;
			acc_q      <= '0;
			streamed_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (head.is_load) begin
							if (streamed_q) begin
								count_q    <= CNT_W'(1);
								ptr_q      <= '0;
								match_q    <= '0;
								acc_q      <= '0;
								streamed_q <= 1'b0;
							end else if (room) begin
								count_q <= CNT_W'(count_q + 1'b1);
							end
						end else begin
							streamed_q <= 1'b1;
							state_q    <= (ptr_q < count_q) ? ST_CMP : ST_END;
						end
					end
				end
				ST_CMP: begin
					if (less) begin
						ptr_q   <= ptr_inc;
						state_q <= (ptr_inc < count_q) ? ST_CMP : ST_END;
					end else if (equal) begin
						ptr_q   <= ptr_inc;
						match_q <= CNT_W'(match_q + 1'b1);
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_END;
					end
				end
				ST_ACC: begin
					acc_q   <= acc_next;
					state_q <= ST_END;
				end
				ST_END: begin
					if (pop) begin
						state_q <= ST_IDLE;
						if (fin_start) begin
							ptr_q   <= '0;
							match_q <= '0;
							acc_q   <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/sedd_finish.sv -----
`default_nettype none
module sedd_finish import sedd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire logic     start,
	input  wire fin_req_t fin_req,
	output logic          busy,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output rsp_t          rsp
);
	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_THR  = 3'd1;
	localparam logic [2:0] F_MUL0 = 3'd2;
	localparam logic [2:0] F_MUL1 = 3'd3;
	localparam logic [2:0] F_DIV  = 3'd4;
	localparam logic [2:0] F_SAT  = 3'd5;
	localparam logic [2:0] F_SQRT = 3'd6;
	localparam logic [2:0] F_OUT  = 3'd7;

	localparam int PROD_W = RES_W + DIM_W;
	localparam int PART_W = 32 + DIM_W;
	localparam int THR_W  = 2 * DIM_W - 16;
	localparam int RAD_W  = RES_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int SREM_W = ROOT_W + 2;
	localparam int ITER_W = $clog2(PROD_W + 1);

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        matches_q;
	logic [MODE_W-1:0]       mode_q;
	logic                    neg_q, below_q;
	logic [RES_W-1:0]        mag_q;
	logic [PART_W-1:0]       part_q;
	logic [PROD_W-1:0]       dvd_q;
	logic [CNT_W-1:0]        rem_q;
	logic [ITER_W-1:0]       iter_q;
	logic signed [RES_W-1:0] res_q;
	logic [RAD_W-1:0]        rad_q;
	logic [ROOT_W-1:0]       root_q;
	logic [SREM_W-1:0]       srem_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic [2*DIM_W-1:0]      thr_prod;
	logic [THR_W-1:0]        thr;
	logic                    below;
	logic [CNT_W:0]          trial;
	logic                    qbit;
	logic [SREM_W-1:0]       srem_sh, strial;
	logic                    rbit;
	logic [ROOT_W-1:0]       root_next;
	logic                    big;
	logic signed [RES_W-1:0] sat_res;
	logic                    out_free;

	assign busy      = (state_q != F_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign thr_prod = cfg.dimension * cfg.fraction;
	assign thr      = thr_prod[2*DIM_W-1:16];
	assign below    = (matches_q == '0) || (THR_W'(matches_q) < thr);

	// restoring divide, one quotient bit a cycle
	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign qbit  = trial >= {1'b0, matches_q};

	// digit-by-digit root, two radicand bits a cycle
	assign srem_sh   = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign strial    = {root_q, 2'b01};
	assign rbit      = srem_sh >= strial;
	assign root_next = {root_q[ROOT_W-2:0], rbit};

	always_comb begin
		big = |dvd_q[PROD_W-1:RES_W-1];
		if (neg_q) begin
			sat_res = big ? SAT_MIN : -$signed(dvd_q[RES_W-1:0]);
		end else begin
			sat_res = big ? SAT_MAX : $signed(dvd_q[RES_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (start) begin
					matches_q <= fin_req.match_cnt;
					mode_q    <= fin_req.mode;
					neg_q     <= fin_req.acc[RES_W-1];
					mag_q     <= fin_req.acc[RES_W-1] ? RES_W'(-fin_req.acc) : fin_req.acc;
				end
			end
			F_THR: begin
				below_q <= below;
				if (below) res_q <= (mode_q == MODE_DOT) ? '0 : NEG_ONE;
			end
			F_MUL0: part_q <= mag_q[31:0] * cfg.dimension;
			F_MUL1: begin
				dvd_q  <= PROD_W'({PART_W'(mag_q[RES_W-1:32]) * PART_W'(cfg.dimension), 32'b0})
				        + PROD_W'(part_q);
				rem_q  <= '0;
				iter_q <= ITER_W'(PROD_W);
			end
			F_DIV: begin
				rem_q  <= qbit ? CNT_W'(trial - {1'b0, matches_q}) : trial[CNT_W-1:0];
				dvd_q  <= {dvd_q[PROD_W-2:0], qbit};
				iter_q <= ITER_W'(iter_q - 1'b1);
			end
			F_SAT: begin
				res_q  <= sat_res;
				rad_q  <= {sat_res, {(2*FRAC_BITS){1'b0}}};
				root_q <= '0;
				srem_q <= '0;
				iter_q <= ITER_W'(ROOT_W);
			end
			F_SQRT: begin
				srem_q <= rbit ? SREM_W'(srem_sh - strial) : srem_sh;
				root_q <= root_next;
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				iter_q <= ITER_W'(iter_q - 1'b1);
				if (iter_q == ITER_W'(1)) res_q <= $signed(RES_W'(root_next));
			end
			F_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == F_OUT && out_free) begin
			rsp_q <= '{result_value: res_q, common_count: matches_q,
			           below_threshold: below_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == F_OUT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				F_IDLE: if (start) state_q <= F_THR;
				F_THR:  state_q <= below ? F_OUT : F_MUL0;
				F_MUL0: state_q <= F_MUL1;
				F_MUL1: state_q <= F_DIV;
				F_DIV:  if (iter_q == ITER_W'(1)) state_q <= F_SAT;
				F_SAT:  state_q <= (mode_q == MODE_LEN && !neg_q) ? F_SQRT : F_OUT;
				F_SQRT: if (iter_q == ITER_W'(1)) state_q <= F_OUT;
				F_OUT:  if (out_free) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/sparse_expected_distance_dot.sv -----
// A transaction is accepted into a two-slot queue ahead of the merge engine. There a load is
// stored from IDLE; a streamed entry passes IDLE, a compare step per stored entry scanned, an
// accumulate step on a match, and END. A last entry then runs the finisher: threshold check,
// then unless below it scaling (81-step divider) and in length mode a square root, while the merge
// engine goes on, one transaction per pass; a last entry waits in END while the finisher is busy.
// Reset: state, counts and config clear at once; the entry store and datapath registers do not.
`default_nettype none
module sparse_expected_distance_dot import sedd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data
);
	// configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [DIM_W-1:0]  dimension_q;
	logic [DIM_W-1:0]  fraction_q;
	cfg_t              cfg;

	// queue head toward the merge engine
	logic     head_valid;
	item_t    head;
	logic     pop;

	// merge engine to finisher handoff
	logic     fin_busy;
	logic     fin_start;
	fin_req_t fin_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_SQD;
			dimension_q <= DIM_W'(65536);
			fraction_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MODE: mode_q      <= cfg_data[MODE_W-1:0];
				CFG_DIM:  dimension_q <= cfg_data;
				CFG_FRAC: fraction_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = '{dimension: dimension_q, fraction: fraction_q};

	// front: accepts each transaction, tags it as load, stream or last, queues it
	sedd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back: stores the first vector and merge-joins the second against it
	sedd_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.mode       (mode_q),
		.fin_busy   (fin_busy),
		.fin_start  (fin_start),
		.fin_req    (fin_req)
	);

	// threshold, scaling divide, optional root; owns the result register
	sedd_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (fin_start),
		.fin_req    (fin_req),
		.busy       (fin_busy),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);
endmodule
`default_nettype wire

// ----- rtl/core/sedd_checker.sv -----
`default_nettype none
`include "sparse_expected_distance_dot_defines.svh"
module sedd_checker import sedd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire rsp_t rsp
);
	`SEDD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`SEDD_ASSERT_SAME(a_below_value, rsp_valid && rsp.below_threshold, rsp.result_value == 64'sd0 || rsp.result_value == NEG_ONE)
	`SEDD_ASSERT_SAME(a_match_nonzero, rsp_valid && !rsp.below_threshold, rsp.common_count != '0)
	`SEDD_ASSERT_SAME(a_count_range, rsp_valid, rsp.common_count <= CNT_W'(MAX_ENTRIES))
endmodule

bind sparse_expected_distance_dot sedd_checker u_sedd_checker (.*);
`default_nettype wire

// ----- verif/sparse_expected_distance_dot_check.sv -----
`default_nettype none
module sparse_expected_distance_dot_check import sedd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire logic                 req_ready,
	input  wire req_t                 req,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire rsp_t                 rsp,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]     cfg_data,
	output int                        errors,
	output int                        pending
);

	logic [IDX_W-1:0]        vec_idx [MAX_ENTRIES];
	logic signed [VAL_W-1:0] vec_val [MAX_ENTRIES];
	int                      vec_cnt;
	int                      join_ptr;
	logic signed [RES_W-1:0] sum_acc;
	int                      hits;
	logic                    streaming;
	logic [MODE_W-1:0]       cur_mode;
	logic [DIM_W-1:0]        cur_dim;
	logic [DIM_W-1:0]        cur_frac;
	rsp_t                    expected_q [$];

	function automatic logic signed [RES_W-1:0] add_sat(logic signed [RES_W-1:0] a,
			logic signed [RES_W-1:0] b);
		logic signed [RES_W:0] s;
		s = {a[RES_W-1], a} + {b[RES_W-1], b};
		if (s > $signed({1'b0, SAT_MAX})) return SAT_MAX;
		if (s < $signed({1'b1, SAT_MIN})) return SAT_MIN;
		return s[RES_W-1:0];
	endfunction

	// floor(sqrt(x << 2*FRAC_BITS))
	function automatic logic [63:0] isqrt_q(logic [63:0] x);
		logic [127:0] n, c, r;
		n = {64'd0, x} << (2 * FRAC_BITS);
		r = '0;
		for (int b = 62; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= n) r = c;
		end
		return r[63:0];
	endfunction

	function automatic logic [63:0] scale_by_dim(logic signed [RES_W-1:0] s, int m);
		logic         neg;
		logic [63:0]  mag, t;
		logic [127:0] q;
		neg = s[RES_W-1];
		mag = neg ? -s : s;
		q = ({64'd0, mag} * {111'd0, cur_dim}) / m;
		if (q[127:64] != 0) return neg ? SAT_MIN : SAT_MAX;
		t = q[63:0];
		if (neg) return (t > 64'h8000_0000_0000_0000) ? SAT_MIN : -t;
		return (t > SAT_MAX) ? SAT_MAX : t;
	endfunction

	function automatic void predict_entry(req_t r);
		logic [MODE_W-1:0]       m;
		logic signed [63:0]      a, b, d;
		logic [63:0]             ad, sq, res;
		logic [33:0]             thr;
		logic                    below;
		rsp_t                    e;
		m = norm_mode(cur_mode);
		if (!r.req_type) begin
			if (streaming) begin
				vec_cnt = 0;
				join_ptr = 0;
				sum_acc = '0;
				hits = 0;
				streaming = 1'b0;
			end
			if (vec_cnt < MAX_ENTRIES) begin
				vec_idx[vec_cnt] = r.entry_index;
				vec_val[vec_cnt] = r.entry_value;
				vec_cnt++;
			end
			return;
		end
		streaming = 1'b1;
		while (join_ptr < vec_cnt && vec_idx[join_ptr] < r.entry_index) join_ptr++;
		if (join_ptr < vec_cnt && vec_idx[join_ptr] == r.entry_index) begin
			a = vec_val[join_ptr];
			b = r.entry_value;
			if (m == MODE_DOT) begin
				sum_acc = add_sat(sum_acc, a * b);
			end else begin
				d = a - b;
				ad = d[63] ? -d : d;
				sq = ad * ad;
				sum_acc = add_sat(sum_acc, (sq > SAT_MAX) ? SAT_MAX : sq);
			end
			join_ptr++;
			hits++;
		end
		if (!r.last_entry) return;
		thr = ({17'd0, cur_dim} * {17'd0, cur_frac}) >> 16;
		below = (hits == 0) || (hits < thr);
		if (below) begin
			res = (m == MODE_DOT) ? 64'd0 : NEG_ONE;
		end else begin
			res = scale_by_dim(sum_acc, hits);
			if (m == MODE_LEN && !res[63]) res = isqrt_q(res);
		end
		e.result_value = res;
		e.common_count = hits[CNT_W-1:0];
		e.below_threshold = below;
		expected_q = {expected_q, e};
		join_ptr = 0;
		sum_acc = '0;
		hits = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			vec_cnt = 0;
			join_ptr = 0;
			sum_acc = '0;
			hits = 0;
			streaming = 1'b0;
			cur_mode = MODE_SQD;
			cur_dim = 17'd65536;
			cur_frac = '0;
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_MODE: cur_mode = cfg_data[MODE_W-1:0];
					CFG_DIM:  cur_dim = cfg_data;
					CFG_FRAC: cur_frac = cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %h", rsp);
				end else begin
					e = expected_q.pop_front();
					if (rsp.result_value !== e.result_value ||
						rsp.common_count !== e.common_count ||
						rsp.below_threshold !== e.below_threshold) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: value %h/%h count %0d/%0d below %b/%b (exp/act)",
								e.result_value, rsp.result_value, e.common_count,
								rsp.common_count, e.below_threshold, rsp.below_threshold);
					end
				end
			end
			if (req_valid && req_ready) predict_entry(req);
			pending = expected_q.size();
		end
	end

endmodule
`default_nettype wire

// ----- verif/sparse_expected_distance_dot_test.sv -----
`default_nettype none
module sparse_expected_distance_dot_test;
	import sedd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;  // idle cycles; a full-store skip scans all stored entries
	localparam int SETTLE_CYCLES  = 200;    // divider + square root + margin
	localparam int RANDOM_ITEMS   = 500;    // the full-store pass adds about 1k more

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_t                 rsp;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;

	int snd_idle;   // percent of cycles the sender holds off
	int rcv_idle;   // percent of cycles the receiver stalls
	int items_sent;
	int quiet_cycles;

	sparse_expected_distance_dot i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sparse_expected_distance_dot_check i_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// receiver backpressure, one decision per falling edge
	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(99) >= rcv_idle);
	end

	// watchdog: any cycle without a transaction on either channel counts
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("sparse_expected_distance_dot_test: errors");
				$finish;
			end
		end
	end

	// One transaction. Called at a falling edge, returns at a falling edge with
	// valid still high, so back-to-back items drop valid in between only when the sender holds off.
	task automatic send_entry(input logic kind, input logic [IDX_W-1:0] idx,
			input logic signed [VAL_W-1:0] val, input logic last);
		while ($urandom_range(99) < snd_idle) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.req_type <= kind;
		req.entry_index <= idx;
		req.entry_value <= val;
		req.last_entry <= last;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		items_sent++;
	endtask

	// Drop valid, wait for all results, then let the finisher drain.
	task automatic drain;
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic configure(input logic [MODE_W-1:0] m, input logic [DIM_W-1:0] d,
			input logic [DIM_W-1:0] f);
		drain();
		write_reg(CFG_MODE, m);
		write_reg(CFG_DIM, d);
		write_reg(CFG_FRAC, f);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom_range(524287)) - 262144;
			2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			3: return 0;
			default: return $signed($urandom_range(8191)) - 4096;
		endcase
	endfunction

	// Random (first, second) vector pair. Mostly well formed; a few are
	// shuffled, carry a stray last mark on a load, or get abandoned mid-stream.
	task automatic random_pair;
		logic [IDX_W-1:0] first_q [$];
		logic [IDX_W-1:0] second_q [$];
		int               n;
		int               base;
		int               spread;
		bit               abandon;
		n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
		base = $urandom_range(65535);
		spread = $urandom_range(1) ? 40 : 65535;
		for (int i = 0; i < n; i++) first_q = {first_q, IDX_W'(base + $urandom_range(spread))};
		first_q.sort();
		foreach (first_q[i]) begin
			if ($urandom_range(99) < 65) second_q = {second_q, first_q[i]};
		end
		n = $urandom_range(3);
		for (int i = 0; i < n; i++) second_q = {second_q, IDX_W'(base + $urandom_range(spread))};
		if (second_q.size() == 0) second_q = {second_q, IDX_W'($urandom)};
		second_q.sort();
		if ($urandom_range(19) == 0) second_q.shuffle();
		abandon = ($urandom_range(19) == 0);
		foreach (first_q[i]) send_entry(1'b0, first_q[i], pick_value(), $urandom_range(9) == 0);
		foreach (second_q[i]) begin
			if (abandon && i == second_q.size() - 1) return;
			send_entry(1'b1, second_q[i], pick_value(), i == second_q.size() - 1);
		end
	endtask

	task automatic random_config;
		logic [MODE_W-1:0] m;
		logic [DIM_W-1:0]  d;
		logic [DIM_W-1:0]  f;
		m = $urandom_range(3);
		case ($urandom_range(3))
			0: d = 17'd1;
			1: d = 17'd65536;
			2: d = $urandom_range(1, 65536);
			default: d = $urandom_range(1, 24);
		endcase
		case ($urandom_range(3))
			0: f = '0;
			1: f = 17'd65536;
			2: f = $urandom_range(65536);
			default: f = $urandom_range(16384);
		endcase
		configure(m, d, f);
	endtask

	task automatic random_phase(input int snd, input int rcv, input int quota);
		int stop_at;
		snd_idle = snd;
		rcv_idle = rcv;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(7) == 0) random_config();
			random_pair();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;
		snd_idle = 0;
		rcv_idle = 0;
		items_sent = 0;
		quiet_cycles = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: extreme indices and values, squared difference clipped.
		send_entry(1'b0, 16'd0, 32'sh8000_0000, 1'b0);
		send_entry(1'b0, 16'd7, 32'sd65536, 1'b1);          // stray last on a load
		send_entry(1'b0, 16'd65535, 32'sh7fff_ffff, 1'b0);
		send_entry(1'b1, 16'd0, 32'sh7fff_ffff, 1'b0);
		send_entry(1'b1, 16'd3, 32'sd1, 1'b0);              // stored index greater: skipped
		send_entry(1'b1, 16'd65535, 32'sh8000_0000, 1'b1);
		// same stored vector reused in product mode, results saturating both ways
		configure(MODE_DOT, 17'd65536, 17'd0);
		send_entry(1'b1, 16'd0, 32'sh8000_0000, 1'b0);
		send_entry(1'b1, 16'd65535, 32'sh7fff_ffff, 1'b1);
		send_entry(1'b1, 16'd0, 32'sh7fff_ffff, 1'b0);
		send_entry(1'b1, 16'd65535, 32'sh8000_0000, 1'b1);
		// length mode; entries past the stored vector do not match
		configure(MODE_LEN, 17'd3, 17'd0);
		send_entry(1'b1, 16'd7, 32'sd0, 1'b0);
		send_entry(1'b1, 16'd65535, 32'sd0, 1'b0);
		send_entry(1'b1, 16'd65535, 32'sd5, 1'b1);
		// new first vector after streaming, then unsorted second vector
		send_entry(1'b0, 16'd10, 32'sd65536, 1'b0);
		send_entry(1'b0, 16'd20, -32'sd65536, 1'b0);
		send_entry(1'b1, 16'd20, 32'sd131072, 1'b0);
		send_entry(1'b1, 16'd10, 32'sd0, 1'b1);
		// mode three with dimension zero, then fractions of one and above
		configure(MODE_RSV, 17'd0, 17'd65536);
		send_entry(1'b1, 16'd10, 32'sd3, 1'b1);
		configure(MODE_SQD, 17'd100, 17'd70000);
		send_entry(1'b1, 16'd10, 32'sd3, 1'b1);
		configure(MODE_DOT, 17'd4, 17'h1ffff);
		send_entry(1'b1, 16'd10, 32'sd3, 1'b1);
		// no matches at all
		configure(MODE_SQD, 17'd65536, 17'd0);
		send_entry(1'b1, 16'd11, 32'sd3, 1'b1);

		random_phase(30, 57, RANDOM_ITEMS / 3);
		drain();   // sender holds off until every result is back
		random_phase(57, 30, RANDOM_ITEMS / 3);

		// full store: the 1025th load is dropped
		configure(MODE_DOT, 17'd65536, 17'd0);
		snd_idle = 0;
		rcv_idle = 0;
		send_entry(1'b1, 16'd0, 32'sd0, 1'b1);   // mark streamed so the next load refills
		for (int i = 0; i <= MAX_ENTRIES; i++)
			send_entry(1'b0, IDX_W'(i * 64), pick_value(), 1'b0);
		send_entry(1'b1, 16'd64, pick_value(), 1'b0);
		send_entry(1'b1, 16'd65472, pick_value(), 1'b0);
		send_entry(1'b1, 16'd65535, pick_value(), 1'b1);

		random_phase(0, 0, RANDOM_ITEMS / 3);

		drain();
		if (errors == 0 && pending == 0) begin
			$display("sparse_expected_distance_dot_test: clean");
		end else begin
			$display("sparse_expected_distance_dot_test: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
